@@ rtl/swer_pkg.sv @@
`default_nettype none
package swer_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic signed [31:0] word_t;

    localparam cnt_t DEPTH_CNT = cnt_t'(STACK_DEPTH);
    localparam word_t POP_EMPTY_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_TRIM = 2'd2,
        REQ_NOP  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_PACK,
        S_DONE
    } state_t;

    // low 8 bits of an entry count
    function automatic logic [7:0] fill8(input cnt_t c);
        logic [CNT_W+7:0] ext;
        ext = {8'd0, c};
        return ext[7:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/stack_with_extremes_removal.sv @@
`default_nettype none
// Bounded LIFO stack of signed 32-bit words held in one on-chip memory with a
// registered read port. Every request gives exactly one result beat. A push,
// an unused request code, a pop of an empty stack and a remove-extremes on an
// empty stack are answered in the cycle after acceptance; a pop first passes
// through the S_POP state for the registered memory read. Remove-extremes on
// N entries makes one sweep through the memory to find the largest and
// smallest values, then a second sweep that reads each entry and writes the
// survivors back down, one entry per cycle. The input is not ready while a
// request is at work or while a result beat waits with the output stalled.
module stack_with_extremes_removal (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic signed [31:0] s_push_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [31:0] m_pop_value,
    output logic [1:0]       m_status,
    output logic [7:0]       m_fill_count
);

    swer_pkg::state_t state_reg, state_next;
    swer_pkg::cnt_t   count_reg, count_next;
    swer_pkg::cnt_t   idx_reg, idx_next;
    swer_pkg::cnt_t   kept_reg, kept_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             seen_reg, seen_next;
    swer_pkg::word_t  hi_reg, hi_next;
    swer_pkg::word_t  lo_reg, lo_next;

    logic             m_valid_reg, m_valid_next;
    swer_pkg::word_t  m_pop_value_reg, m_pop_value_next;
    swer_pkg::status_t m_status_reg, m_status_next;
    logic [7:0]       m_fill_count_reg, m_fill_count_next;

    swer_pkg::word_t  mem [swer_pkg::STACK_DEPTH];
    swer_pkg::word_t  rd_data_reg;
    logic             mem_we;
    swer_pkg::addr_t  mem_waddr;
    swer_pkg::word_t  mem_wdata;
    swer_pkg::addr_t  mem_raddr;
    swer_pkg::cnt_t   count_dec;

    logic             s_fire;
    logic             ld_out;
    logic             sweep_end;

    assign s_ready   = (state_reg == swer_pkg::S_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire    = s_valid && s_ready;
    assign sweep_end = (idx_reg == count_reg) && !rd_pend_reg;
    assign count_dec = count_reg - swer_pkg::cnt_t'(1);

    assign m_valid      = m_valid_reg;
    assign m_pop_value  = m_pop_value_reg;
    assign m_status     = m_status_reg;
    assign m_fill_count = m_fill_count_reg;

    // stack memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swer_pkg::S_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg          <= idx_next;
        kept_reg         <= kept_next;
        seen_reg         <= seen_next;
        hi_reg           <= hi_next;
        lo_reg           <= lo_next;
        m_pop_value_reg  <= m_pop_value_next;
        m_status_reg     <= m_status_next;
        m_fill_count_reg <= m_fill_count_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swer_pkg::S_IDLE: begin
                if (s_fire) begin
                    case (swer_pkg::req_t'(s_req_type))
                        swer_pkg::REQ_POP: begin
                            if (count_reg != '0) begin
                                state_next = swer_pkg::S_POP;
                            end
                        end
                        swer_pkg::REQ_TRIM: begin
                            if (count_reg != '0) begin
                                state_next = swer_pkg::S_SCAN;
                            end
                        end
                        default: state_next = swer_pkg::S_IDLE;
                    endcase
                end
            end
            swer_pkg::S_POP:  state_next = swer_pkg::S_IDLE;
            swer_pkg::S_SCAN: begin
                if (sweep_end) begin
                    state_next = swer_pkg::S_PACK;
                end
            end
            swer_pkg::S_PACK: begin
                if (sweep_end) begin
                    state_next = swer_pkg::S_DONE;
                end
            end
            swer_pkg::S_DONE: state_next = swer_pkg::S_IDLE;
            default:          state_next = swer_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        count_next        = count_reg;
        idx_next          = idx_reg;
        kept_next         = kept_reg;
        rd_pend_next      = 1'b0;
        seen_next         = seen_reg;
        hi_next           = hi_reg;
        lo_next           = lo_reg;
        mem_we            = 1'b0;
        mem_waddr         = count_reg[swer_pkg::ADDR_W-1:0];
        mem_wdata         = s_push_value;
        mem_raddr         = idx_reg[swer_pkg::ADDR_W-1:0];
        ld_out            = 1'b0;
        m_pop_value_next  = m_pop_value_reg;
        m_status_next     = m_status_reg;
        m_fill_count_next = m_fill_count_reg;

        case (state_reg)
            swer_pkg::S_IDLE: begin
                mem_raddr         = count_dec[swer_pkg::ADDR_W-1:0];
                idx_next          = '0;
                seen_next         = 1'b0;
                if (s_fire) begin
                    m_pop_value_next  = '0;
                    m_status_next     = swer_pkg::STAT_OK;
                    m_fill_count_next = swer_pkg::fill8(count_reg);
                    case (swer_pkg::req_t'(s_req_type))
                        swer_pkg::REQ_PUSH: begin
                            ld_out = 1'b1;
                            if (count_reg >= swer_pkg::DEPTH_CNT) begin
                                m_status_next = swer_pkg::STAT_FULL;
                            end else begin
                                mem_we            = 1'b1;
                                count_next        = count_reg + swer_pkg::cnt_t'(1);
                                m_fill_count_next = swer_pkg::fill8(count_next);
                            end
                        end
                        swer_pkg::REQ_POP: begin
                            if (count_reg == '0) begin
                                ld_out           = 1'b1;
                                m_status_next    = swer_pkg::STAT_EMPTY;
                                m_pop_value_next = swer_pkg::POP_EMPTY_VALUE;
                            end else begin
                                count_next = count_dec;
                            end
                        end
                        swer_pkg::REQ_TRIM: begin
                            ld_out = (count_reg == '0);
                        end
                        default: ld_out = 1'b1;
                    endcase
                end
            end
            swer_pkg::S_POP: begin
                ld_out            = 1'b1;
                m_pop_value_next  = rd_data_reg;
                m_status_next     = swer_pkg::STAT_OK;
                m_fill_count_next = swer_pkg::fill8(count_reg);
            end
            swer_pkg::S_SCAN: begin
                if (idx_reg != count_reg) begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + swer_pkg::cnt_t'(1);
                end
                if (rd_pend_reg) begin
                    seen_next = 1'b1;
                    if (!seen_reg || (rd_data_reg > hi_reg)) begin
                        hi_next = rd_data_reg;
                    end
                    if (!seen_reg || (rd_data_reg < lo_reg)) begin
                        lo_next = rd_data_reg;
                    end
                end
                if (sweep_end) begin
                    idx_next  = '0;
                    kept_next = '0;
                end
            end
            swer_pkg::S_PACK: begin
                mem_waddr = kept_reg[swer_pkg::ADDR_W-1:0];
                mem_wdata = rd_data_reg;
                if (idx_reg != count_reg) begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + swer_pkg::cnt_t'(1);
                end
                // keep entries that are neither extreme, sliding them down
                if (rd_pend_reg && (rd_data_reg != hi_reg) && (rd_data_reg != lo_reg)) begin
                    mem_we    = 1'b1;
                    kept_next = kept_reg + swer_pkg::cnt_t'(1);
                end
            end
            swer_pkg::S_DONE: begin
                ld_out            = 1'b1;
                count_next        = kept_reg;
                m_pop_value_next  = '0;
                m_status_next     = swer_pkg::STAT_OK;
                m_fill_count_next = swer_pkg::fill8(kept_reg);
            end
            default: ld_out = 1'b0;
        endcase

        if (ld_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // stack never holds more than its depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= swer_pkg::DEPTH_CNT)
        else $error("entry count beyond stack depth");

    // a new result never overwrites a stalled beat
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !ld_out)
        else $error("result overwritten while stalled");

    // compaction keeps no more entries than it has read
    a_pack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == swer_pkg::S_PACK) |-> (kept_reg <= idx_reg))
        else $error("compaction write pointer ahead of read pointer");

    // an accepted push onto a non-full stack grows it by one
    a_push_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_req_type == swer_pkg::REQ_PUSH)
            && (count_reg < swer_pkg::DEPTH_CNT))
        |=> (count_reg == $past(count_reg) + swer_pkg::cnt_t'(1)))
        else $error("push did not grow the stack");
`endif

endmodule
`default_nettype wire

@@ tb/stack_with_extremes_removal_tb.sv @@
`timescale 1ns / 1ps
module stack_with_extremes_removal_tb;

    localparam int IDLE_LIMIT = 3000;

    typedef struct {
        swer_pkg::req_t  req;
        swer_pkg::word_t value;
        bit              drain_first;
    } stack_req_t;

    typedef struct {
        swer_pkg::word_t   pop_value;
        swer_pkg::status_t status;
        logic [7:0]        fill;
    } stack_rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = swer_pkg::REQ_NOP;
    logic signed [31:0] s_push_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [31:0] m_pop_value;
    logic [1:0]  m_status;
    logic [7:0]  m_fill_count;

    stack_with_extremes_removal dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_type  (s_req_type),
        .s_push_value(s_push_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pop_value (m_pop_value),
        .m_status    (m_status),
        .m_fill_count(m_fill_count)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // shadow stack and the results it predicts
    swer_pkg::word_t stack_mem [swer_pkg::STACK_DEPTH];
    int         stack_fill = 0;
    stack_rsp_t rsp_expected [$];
    stack_req_t req_pending [$];

    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int gap_left = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int issued = 0;
    bit hold_done = 1'b0;
    stack_req_t next_req;
    stack_rsp_t want;
    int roll;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] exp_val);
        $display("mismatch at %0t ns: %s got %h, wanted %h", $time, what, got, exp_val);
        errors++;
    endtask

    task automatic stack_apply(input swer_pkg::req_t req, input swer_pkg::word_t value);
        stack_rsp_t rsp;
        swer_pkg::word_t hi;
        swer_pkg::word_t lo;
        int kept;
        int i;
        rsp.pop_value = '0;
        rsp.status = swer_pkg::STAT_OK;
        case (req)
            swer_pkg::REQ_PUSH: begin
                if (stack_fill >= swer_pkg::STACK_DEPTH) begin
                    rsp.status = swer_pkg::STAT_FULL;
                end else begin
                    stack_mem[stack_fill] = value;
                    stack_fill++;
                end
            end
            swer_pkg::REQ_POP: begin
                if (stack_fill == 0) begin
                    rsp.status = swer_pkg::STAT_EMPTY;
                    rsp.pop_value = swer_pkg::POP_EMPTY_VALUE;
                end else begin
                    stack_fill--;
                    rsp.pop_value = stack_mem[stack_fill];
                end
            end
            swer_pkg::REQ_TRIM: begin
                if (stack_fill > 0) begin
                    hi = stack_mem[0];
                    lo = hi;
                    for (i = 1; i < stack_fill; i++) begin
                        if (stack_mem[i] > hi) hi = stack_mem[i];
                        if (stack_mem[i] < lo) lo = stack_mem[i];
                    end
                    kept = 0;
                    for (i = 0; i < stack_fill; i++) begin
                        if (stack_mem[i] != hi && stack_mem[i] != lo) begin
                            stack_mem[kept] = stack_mem[i];
                            kept++;
                        end
                    end
                    stack_fill = kept;
                end
            end
            default: ;
        endcase
        rsp.fill = 8'(stack_fill);
        rsp_expected.push_back(rsp);
    endtask

    function automatic int pick_gap(input int idx);
        int r;
        r = $urandom_range(0, 99);
        if (idx % 120 < 30) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic swer_pkg::word_t rand_word();
        int r;
        r = $urandom_range(0, 99);
        // narrow range makes duplicates so trims drop several entries
        if (r < 40) return swer_pkg::word_t'($urandom_range(0, 15)) - 8;
        if (r < 55) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return swer_pkg::word_t'($urandom);
    endfunction

    function automatic swer_pkg::req_t rand_req();
        int r;
        r = $urandom_range(0, 99);
        if (r < 52) return swer_pkg::REQ_PUSH;
        if (r < 84) return swer_pkg::REQ_POP;
        if (r < 94) return swer_pkg::REQ_TRIM;
        return swer_pkg::REQ_NOP;
    endfunction

    task automatic add_req(input swer_pkg::req_t req, input swer_pkg::word_t value,
                           input bit drain_first);
        stack_req_t item;
        item.req = req;
        item.value = value;
        item.drain_first = drain_first;
        req_pending.push_back(item);
    endtask

    task automatic add_mixed(input int count);
        int k;
        for (k = 0; k < count; k++)
            add_req(rand_req(), rand_word(), $urandom_range(0, 99) < 2);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                stack_apply(swer_pkg::req_t'(s_req_type), s_push_value);
                beats_in <= beats_in + 1;
            end
            if (s_valid && !s_ready) begin
                // hold the beat until taken
            end else if (gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (req_pending.size() > 0 &&
                         !(req_pending[0].drain_first &&
                           beats_in + (s_valid && s_ready) != beats_out)) begin
                next_req = req_pending.pop_front();
                s_valid <= 1'b1;
                s_req_type <= next_req.req;
                s_push_value <= next_req.value;
                gap_left <= pick_gap(issued);
                issued <= issued + 1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && beats_out >= 60) begin
            // long hold so the block backs up and stalls its input
            m_ready <= 1'b0;
            stall_left <= 400;
            hold_done <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (beats_out % 150 < 40) begin
            m_ready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall_left <= (roll < 92) ? $urandom_range(0, 2) : $urandom_range(10, 50);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            beats_out <= beats_out + 1;
            if (rsp_expected.size() == 0) begin
                report("result beat with none pending", m_fill_count, '0);
            end else begin
                want = rsp_expected.pop_front();
                if (m_pop_value !== want.pop_value)
                    report("pop_value", m_pop_value, want.pop_value);
                if (m_status !== want.status)
                    report("status", m_status, want.status);
                if (m_fill_count !== want.fill)
                    report("fill_count", m_fill_count, want.fill);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("stack_with_extremes_removal test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int k;
        // empty stack corner cases
        add_req(swer_pkg::REQ_POP, 32'sd0, 1'b0);
        add_req(swer_pkg::REQ_TRIM, 32'sd0, 1'b0);
        add_req(swer_pkg::REQ_NOP, 32'sh7fffffff, 1'b0);
        // all entries equal
        for (k = 0; k < 3; k++) add_req(swer_pkg::REQ_PUSH, 32'sd7, 1'b0);
        add_req(swer_pkg::REQ_TRIM, 32'sd0, 1'b0);
        // field extremes, then a trim that keeps the middle values
        add_req(swer_pkg::REQ_PUSH, 32'sh7fffffff, 1'b0);
        add_req(swer_pkg::REQ_PUSH, 32'sh80000000, 1'b0);
        add_req(swer_pkg::REQ_PUSH, 32'sd0, 1'b0);
        add_req(swer_pkg::REQ_PUSH, -32'sd1, 1'b0);
        add_req(swer_pkg::REQ_PUSH, 32'sh7fffffff, 1'b0);
        add_req(swer_pkg::REQ_PUSH, 32'sh55555555, 1'b0);
        add_req(swer_pkg::REQ_PUSH, 32'shaaaaaaaa, 1'b0);
        add_req(swer_pkg::REQ_POP, 32'sd0, 1'b0);
        add_req(swer_pkg::REQ_TRIM, 32'sd0, 1'b0);
        add_req(swer_pkg::REQ_NOP, 32'shffffffff, 1'b0);
        add_req(swer_pkg::REQ_POP, 32'sd0, 1'b0);
        add_req(swer_pkg::REQ_POP, 32'sd0, 1'b0);
        add_req(swer_pkg::REQ_POP, 32'sd0, 1'b0);
        add_req(swer_pkg::REQ_POP, 32'sd0, 1'b0);

        add_mixed(120);
        // fill past full after letting everything drain, trim, then empty it out
        add_req(swer_pkg::REQ_PUSH, rand_word(), 1'b1);
        for (k = 0; k < 132; k++) add_req(swer_pkg::REQ_PUSH, rand_word(), 1'b0);
        add_req(swer_pkg::REQ_TRIM, 32'sd0, 1'b0);
        for (k = 0; k < 131; k++) add_req(swer_pkg::REQ_POP, rand_word(), 1'b0);
        add_mixed(150);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_pending.size() > 0 || s_valid || rsp_expected.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("stack_with_extremes_removal test passed");
        else
            $display("stack_with_extremes_removal test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/swer_pkg.sv
rtl/stack_with_extremes_removal.sv
tb/stack_with_extremes_removal_tb.sv
